>>> design/mpsm_pkg.sv
// ---------------------------------------------------------------------------
// mpsm_pkg
// shared types and constants of the multi-pattern string matcher
// ---------------------------------------------------------------------------
package mpsm_pkg;

  // function codes of a request
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_BUILD  = 2'd1;
  localparam logic [1:0] FUNC_SCAN   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MATCH   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_TOOLONG = 3'd3;
  localparam logic [2:0] ST_BUILT   = 3'd4;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0] func;
    logic [4:0] symbol;
    logic       pattern_end;
  } mpsm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  match_len;
    logic [15:0] match_count;
    logic [15:0] end_pos;
    logic        last;
  } mpsm_out_t;

endpackage

>>> design/multi_pattern_string_matcher.sv
// ---------------------------------------------------------------------------
// multi_pattern_string_matcher
// aho-corasick dictionary matcher with a trie, build pass and text scanner
// ---------------------------------------------------------------------------
// After reset the block sweeps its goto, fail, term, count and depth memories
// to zero, walking every goto entry, with busy high. All node state lives in
// rams with one write port, one read port and registered read, walked by one
// sequencer, so every ram read returns its data registered. An insert reads
// depth and child, then writes the new node; one that ends a pattern also
// reads and bumps the node's count. A rejected or ignored request goes
// straight to its result. A scan reads the transition, checks the node and
// its terminal link, then reports one match per node along the terminal chain.
// A build reads each node's fail and term links, then goto entries per letter.
// Results appear on out_valid for one cycle each and cannot be held off by the receiver.
module multi_pattern_string_matcher
  import mpsm_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int ALPHABET  = 26,
  parameter int MAX_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mpsm_in_t  in_req,
  output logic      out_valid,
  output mpsm_out_t out_res
);

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int GD = MAX_NODES * ALPHABET;
  localparam int GW = $clog2(GD);
  localparam int CW = NW + 1;
  localparam logic [CW-1:0] NODES_C = CW'(MAX_NODES);
  localparam logic [AW:0] ALPH_C = (AW+1)'(ALPHABET);
  localparam logic [5:0] DEPTH_C = 6'(MAX_DEPTH);

  typedef enum logic [15:0] {
    S_CLR  = 16'h0001,
    S_IDLE = 16'h0002,
    S_IRD  = 16'h0004,
    S_IWT  = 16'h0008,
    S_IDO  = 16'h0010,
    S_CWT  = 16'h0020,
    S_BPOP = 16'h0040,
    S_BF   = 16'h0080,
    S_BT   = 16'h0100,
    S_BCR  = 16'h0200,
    S_BCW  = 16'h0400,
    S_BCD  = 16'h0800,
    S_SRD  = 16'h1000,
    S_SWT  = 16'h2000,
    S_SND  = 16'h4000,
    S_SCH  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  // ram ports
  logic          g_we;  logic [GW-1:0] g_wa, g_ra; logic [NW-1:0] g_wd, g_rd;
  logic          f_we;  logic [NW-1:0] f_wa, f_ra, f_wd, f_rd;
  logic          t_we;  logic [NW-1:0] t_wa, t_ra, t_wd, t_rd;
  logic          c_we;  logic [NW-1:0] c_wa, c_ra; logic [15:0] c_wd, c_rd;
  logic          d_we;  logic [NW-1:0] d_wa, d_ra; logic [5:0] d_wd, d_rd;
  logic          q_we;  logic [NW-1:0] q_wa, q_ra, q_wd, q_rd;

  mpsm_ram #(.WIDTH(NW), .DEPTH(GD)) u_goto (.clk, .we(g_we), .waddr(g_wa),
    .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (.clk, .we(f_we), .waddr(f_wa),
    .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_term (.clk, .we(t_we), .waddr(t_wa),
    .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  mpsm_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_cnt (.clk, .we(c_we), .waddr(c_wa),
    .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  mpsm_ram #(.WIDTH(6), .DEPTH(MAX_NODES)) u_dep (.clk, .we(d_we), .waddr(d_wa),
    .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
  mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (.clk, .we(q_we), .waddr(q_wa),
    .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  // control and working registers
  logic [GW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [NW-1:0] ins_r, ins_nxt, scan_r, scan_nxt;
  logic [15:0]   pos_r, pos_nxt;
  logic          built_r, built_nxt;
  logic [2:0]    drop_r, drop_nxt;
  mpsm_in_t      req_r, req_nxt;
  logic [NW-1:0] id_r, id_nxt, f_r, f_nxt, cur_r, cur_nxt, ch_r, ch_nxt;
  logic [GW-1:0] base_r, base_nxt, fbase_r, fbase_nxt;
  logic [AW:0]   sym_r, sym_nxt;
  logic [CW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [5:0]    k_r, k_nxt;
  logic [5:0]    dep_r, dep_nxt;
  logic          ov_r, ov_nxt;
  mpsm_out_t     res_r, res_nxt;

  // node index times alphabet, one multiply then a register
  function automatic logic [GW-1:0] row(input logic [NW-1:0] n);
    row = GW'(n * ALPHABET);
  endfunction

  always_comb begin
    logic [AW-1:0] s;
    s = req_r.symbol[AW-1:0];
    state_nxt = state_r;
    clr_nxt = clr_r; used_nxt = used_r; ins_nxt = ins_r; scan_nxt = scan_r;
    pos_nxt = pos_r; built_nxt = built_r; drop_nxt = drop_r; req_nxt = req_r;
    id_nxt = id_r; f_nxt = f_r; cur_nxt = cur_r; ch_nxt = ch_r;
    base_nxt = base_r; fbase_nxt = fbase_r; sym_nxt = sym_r;
    head_nxt = head_r; tail_nxt = tail_r; k_nxt = k_r; dep_nxt = dep_r;
    res_nxt = res_r; ov_nxt = 1'b0;
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
    c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
    d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
    case (state_r)
      // zero sweep after reset
      S_CLR: begin
        g_we = 1'b1; g_wa = clr_r;
        f_we = 1'b1; f_wa = clr_r[NW-1:0];
        t_we = 1'b1; t_wa = clr_r[NW-1:0];
        c_we = 1'b1; c_wa = clr_r[NW-1:0];
        d_we = 1'b1; d_wa = clr_r[NW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == GW'(GD - 1)) state_nxt = S_IDLE;
      end
      // take a request once the last result has gone out
      S_IDLE: begin
        if (start && !ov_r) begin
          req_nxt = in_req;
          if (in_req.func == FUNC_INSERT) begin
            res_nxt = '0; res_nxt.last = 1'b1;
            if (built_r) begin
              res_nxt.status = ST_BUILT; ov_nxt = 1'b1;
            end else if ({1'b0, in_req.symbol} >= 6'(ALPHABET)) begin
              ov_nxt = 1'b1;
            end else begin
              base_nxt = row(ins_r);
              state_nxt = S_IRD;
            end
          end else if (in_req.func == FUNC_BUILD) begin
            res_nxt = '0; res_nxt.last = 1'b1;
            if (built_r) begin
              ov_nxt = 1'b1;
            end else begin
              q_we = 1'b1; q_wa = '0; q_wd = '0;
              head_nxt = '0; tail_nxt = CW'(1);
              state_nxt = S_BPOP;
            end
          end else if (in_req.func == FUNC_SCAN) begin
            pos_nxt = pos_r + 16'd1;
            base_nxt = row(scan_r);
            state_nxt = S_SRD;
          end else begin
            res_nxt = '0; res_nxt.last = 1'b1; ov_nxt = 1'b1;
          end
        end
      end
      // insert: read depth and child
      S_IRD: begin
        d_ra = ins_r; g_ra = base_r + GW'(s);
        state_nxt = S_IWT;
      end
      S_IWT: begin
        state_nxt = S_IDO;
        ch_nxt = g_rd; dep_nxt = d_rd;
      end
      S_IDO: begin
        state_nxt = S_IDLE; ov_nxt = 1'b1;
        if (drop_r == ST_OK) begin
          if (dep_r >= DEPTH_C) begin
            drop_nxt = ST_TOOLONG;
          end else if (ch_r == '0 && used_r >= NODES_C) begin
            drop_nxt = ST_FULL;
          end else begin
            cur_nxt = ch_r;
            if (ch_r == '0) begin
              cur_nxt = used_r[NW-1:0];
              used_nxt = used_r + 1'b1;
              d_we = 1'b1; d_wa = used_r[NW-1:0]; d_wd = dep_r + 6'd1;
              g_we = 1'b1; g_wa = base_r + GW'(s); g_wd = used_r[NW-1:0];
            end
            ins_nxt = cur_nxt;
            if (req_r.pattern_end) begin
              ins_nxt = '0; k_nxt = '0;
              ov_nxt = 1'b0; state_nxt = S_CWT;
            end
          end
        end
        if (drop_nxt != ST_OK) begin
          res_nxt.status = drop_nxt;
          if (req_r.pattern_end) begin
            drop_nxt = ST_OK; ins_nxt = '0;
          end
        end
      end
      // count bump: read then saturating write
      S_CWT: begin
        c_ra = cur_r;
        state_nxt = S_IWT;
        if (k_r == 6'd1) begin
          k_nxt = '0;
          c_we = 1'b1; c_wa = cur_r;
          c_wd = (c_rd < CNT_MAX) ? c_rd + 16'd1 : c_rd;
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          k_nxt = 6'd1; state_nxt = S_CWT;
        end
      end
      // build: pop queue
      S_BPOP: begin
        if (head_r < tail_r && head_r < NODES_C) begin
          q_ra = head_r[NW-1:0];
          head_nxt = head_r + 1'b1;
          k_nxt = '0;
          state_nxt = S_BF;
        end else begin
          built_nxt = 1'b1; ins_nxt = '0; drop_nxt = ST_OK;
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      // read fail link of popped node
      S_BF: begin
        if (k_r == '0) begin
          id_nxt = q_rd; f_ra = q_rd; k_nxt = 6'd1;
        end else begin
          f_nxt = f_rd; c_ra = f_rd; t_ra = f_rd;
          base_nxt = row(id_r); fbase_nxt = row(f_rd);
          k_nxt = '0; state_nxt = S_BT;
        end
      end
      // term link of node, fail node reads issued once more in this state
      S_BT: begin
        if (k_r == '0) begin
          c_ra = f_r; t_ra = f_r;
          k_nxt = 6'd1;
        end else begin
          t_we = 1'b1; t_wa = id_r;
          t_wd = (c_rd != '0) ? f_r : t_rd;
          sym_nxt = '0; k_nxt = '0; state_nxt = S_BCR;
        end
      end
      // per letter: read own and fail-side goto
      S_BCR: begin
        if (sym_r >= ALPH_C) begin
          state_nxt = S_BPOP;
        end else begin
          g_ra = base_r + GW'(sym_r);
          state_nxt = S_BCW;
        end
      end
      S_BCW: begin
        ch_nxt = g_rd;
        g_ra = fbase_r + GW'(sym_r);
        state_nxt = S_BCD;
      end
      S_BCD: begin
        if (ch_r != '0) begin
          f_we = 1'b1; f_wa = ch_r; f_wd = (id_r != '0) ? g_rd : '0;
          if (tail_r < NODES_C) begin
            q_we = 1'b1; q_wa = tail_r[NW-1:0]; q_wd = ch_r;
            tail_nxt = tail_r + 1'b1;
          end
        end else begin
          g_we = 1'b1; g_wa = base_r + GW'(sym_r); g_wd = g_rd;
        end
        sym_nxt = sym_r + 1'b1;
        state_nxt = S_BCR;
      end
      // scan: transition read
      S_SRD: begin
        g_ra = base_r + GW'(s);
        state_nxt = S_SWT;
      end
      S_SWT: begin
        cur_nxt = ({1'b0, req_r.symbol} >= 6'(ALPHABET)) ? '0 : g_rd;
        scan_nxt = cur_nxt;
        c_ra = cur_nxt; t_ra = cur_nxt; d_ra = cur_nxt;
        k_nxt = '0;
        state_nxt = S_SND;
      end
      // first node check: self or its terminal link
      S_SND: begin
        if (c_rd != '0) begin
          state_nxt = S_SCH;
          c_ra = cur_r; t_ra = cur_r; d_ra = cur_r;
        end else if (t_rd != '0) begin
          cur_nxt = t_rd;
          c_ra = t_rd; t_ra = t_rd; d_ra = t_rd;
          state_nxt = S_SCH;
        end else begin
          res_nxt = '0; res_nxt.end_pos = pos_r - 16'd1; res_nxt.last = 1'b1;
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      // emit one match per chain node
      S_SCH: begin
        res_nxt.status = ST_MATCH;
        res_nxt.match_len = d_rd;
        res_nxt.match_count = c_rd;
        res_nxt.end_pos = pos_r - 16'd1;
        ov_nxt = 1'b1;
        k_nxt = k_r + 6'd1;
        cur_nxt = t_rd;
        if (t_rd == '0 || k_nxt >= DEPTH_C) begin
          res_nxt.last = 1'b1; state_nxt = S_IDLE;
        end else begin
          res_nxt.last = 1'b0;
          c_ra = t_rd; t_ra = t_rd; d_ra = t_rd;
          state_nxt = S_SCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; used_r <= CW'(1);
      ins_r <= '0; scan_r <= '0; pos_r <= '0; built_r <= 1'b0;
      drop_r <= ST_OK; ov_r <= 1'b0; k_r <= '0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; used_r <= used_nxt;
      ins_r <= ins_nxt; scan_r <= scan_nxt; pos_r <= pos_nxt;
      built_r <= built_nxt; drop_r <= drop_nxt; ov_r <= ov_nxt; k_r <= k_nxt;
    end
    req_r <= req_nxt; id_r <= id_nxt; f_r <= f_nxt; cur_r <= cur_nxt;
    ch_r <= ch_nxt; base_r <= base_nxt; fbase_r <= fbase_nxt;
    sym_r <= sym_nxt; head_r <= head_nxt; tail_r <= tail_nxt;
    dep_r <= dep_nxt; res_r <= res_nxt;
  end

  assign busy = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_res = res_r;

endmodule

>>> design/mpsm_ram.sv
// ---------------------------------------------------------------------------
// mpsm_ram
// generic single-port write, single-port read ram with registered read
// ---------------------------------------------------------------------------
module mpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/mpsm_checker.sv
// ---------------------------------------------------------------------------
// mpsm_checker
// port-level checks of the matcher, bound to the top level
// ---------------------------------------------------------------------------
module mpsm_checker
  import mpsm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input mpsm_in_t  in_req,
  input logic      out_valid,
  input mpsm_out_t out_res
);

  // a result is only shown while busy
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside busy");

  // no match reports carry a zero length
  a_nomatch_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != ST_MATCH) |-> out_res.match_len == '0)
    else $error("length on non-match");

  // a final result is never followed by another in the next cycle
  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last) |=> !out_valid)
    else $error("result after last");

  // match results carry a nonzero count
  a_match_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status == ST_MATCH) |-> out_res.match_count != '0)
    else $error("match with zero count");

endmodule

bind multi_pattern_string_matcher mpsm_checker u_mpsm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
  .out_valid(out_valid), .out_res(out_res));

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// self-checking bench of the multi-pattern string matcher: a queue-fed driver
// issues insert, build and scan requests while a predictor of the automaton
// keeps a queue of expected results that the monitor checks in order
// ---------------------------------------------------------------------------
module testbench;
  import mpsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES    = 1024;
  localparam int LETTERS  = 26;
  localparam int DEPTH    = 32;
  localparam int WD_LIMIT = 300000;
  localparam int QUIET    = 80;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  mpsm_in_t  in_req;
  logic      out_valid;
  mpsm_out_t out_res;

  multi_pattern_string_matcher u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // shadow automaton
  logic [9:0]  sh_goto [NODES*LETTERS];
  logic [9:0]  sh_fail [NODES];
  logic [9:0]  sh_term [NODES];
  logic [15:0] sh_cnt  [NODES];
  logic [5:0]  sh_depth[NODES];
  logic [9:0]  sh_bfs  [NODES];
  int          sh_used;
  int          sh_ins;
  int          sh_scan;
  logic [15:0] sh_pos;
  bit          sh_built;
  logic [2:0]  sh_drop;

  mpsm_in_t  pending_reqs[$];
  mpsm_out_t expected_res[$];
  int        mismatches;
  int        idle_cycles;
  int        gap;
  bit        fired;

  function automatic mpsm_out_t mk_res(logic [2:0] st, logic [5:0] len, logic [15:0] cnt,
                                       logic [15:0] pos, logic lst);
    mpsm_out_t r;
    r.status = st; r.match_len = len; r.match_count = cnt; r.end_pos = pos; r.last = lst;
    return r;
  endfunction

  // breadth-first pass: failure links, terminal links, full transitions
  function automatic void build_automaton();
    int head, tail, id, f, child;
    head = 0;
    tail = 0;
    sh_bfs[tail++] = 0;
    while (head < tail) begin
      id = sh_bfs[head++];
      f  = sh_fail[id];
      sh_term[id] = (sh_cnt[f] != 0) ? 10'(f) : sh_term[f];
      for (int c = 0; c < LETTERS; c++) begin
        child = sh_goto[id*LETTERS+c];
        if (child != 0) begin
          sh_fail[child] = (id != 0) ? sh_goto[f*LETTERS+c] : 10'd0;
          if (tail < NODES) sh_bfs[tail++] = 10'(child);
        end else begin
          sh_goto[id*LETTERS+c] = sh_goto[f*LETTERS+c];
        end
      end
    end
  endfunction

  function automatic logic [2:0] insert_letter(int sym, logic pend);
    int child;
    logic [2:0] st;
    if (sh_built) return ST_BUILT;
    if (sym >= LETTERS) return ST_OK;
    if (sh_drop == ST_OK) begin
      if (sh_depth[sh_ins] >= DEPTH) begin
        sh_drop = ST_TOOLONG;
      end else begin
        child = sh_goto[sh_ins*LETTERS+sym];
        if (child == 0) begin
          if (sh_used >= NODES) begin
            sh_drop = ST_FULL;
          end else begin
            child = sh_used++;
            sh_depth[child] = sh_depth[sh_ins] + 6'd1;
            sh_goto[sh_ins*LETTERS+sym] = 10'(child);
          end
        end
        if (sh_drop == ST_OK) begin
          sh_ins = child;
          if (pend) begin
            if (sh_cnt[sh_ins] != CNT_MAX) sh_cnt[sh_ins]++;
            sh_ins = 0;
          end
          return ST_OK;
        end
      end
    end
    st = sh_drop;
    if (pend) begin
      sh_drop = ST_OK;
      sh_ins  = 0;
    end
    return st;
  endfunction

  // expected results of one accepted request
  function automatic void predict_results(mpsm_in_t r);
    int node, cur, k;
    logic [15:0] p;
    case (r.func)
      FUNC_INSERT: begin
        expected_res.push_back(mk_res(insert_letter(r.symbol, r.pattern_end), '0, '0, '0,
                                      1'b1));
      end
      FUNC_BUILD: begin
        if (!sh_built) begin
          build_automaton();
          sh_built = 1'b1;
          sh_ins   = 0;
          sh_drop  = ST_OK;
        end
        expected_res.push_back(mk_res(ST_OK, '0, '0, '0, 1'b1));
      end
      FUNC_SCAN: begin
        p = sh_pos;
        sh_pos++;
        node = (r.symbol >= LETTERS) ? 0 : sh_goto[sh_scan*LETTERS+r.symbol];
        sh_scan = node;
        cur = (sh_cnt[node] != 0) ? node : sh_term[node];
        k = 0;
        while (cur != 0 && k < DEPTH) begin
          expected_res.push_back(mk_res(ST_MATCH, sh_depth[cur], sh_cnt[cur], p, 1'b0));
          k++;
          cur = sh_term[cur];
        end
        if (k == 0) expected_res.push_back(mk_res(ST_OK, '0, '0, p, 1'b1));
        else expected_res[$].last = 1'b1;
      end
      default: begin
        expected_res.push_back(mk_res(ST_OK, '0, '0, '0, 1'b1));
      end
    endcase
  endfunction

  task automatic add_req(logic [1:0] f, int sym, logic pend);
    mpsm_in_t r;
    r.func = f; r.symbol = 5'(sym); r.pattern_end = pend;
    pending_reqs.push_back(r);
  endtask

  // random request with mostly small letters, some noise and odd codes
  task automatic add_random(logic [1:0] f);
    int sym;
    sym = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(0, 31);
    if ($urandom_range(0, 19) == 0) f = 2'($urandom_range(0, 3));
    add_req(f, sym, 1'($urandom_range(0, 2) == 0));
  endtask

  // acceptance and result checking
  always @(posedge clk) begin
    mpsm_out_t e;
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) begin
        predict_results(in_req);
        fired = 1'b1;
      end
      if (out_valid) begin
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_res);
        end else begin
          e = expected_res.pop_front();
          if (out_res.status != e.status || out_res.match_len != e.match_len ||
              out_res.match_count != e.match_count || out_res.end_pos != e.end_pos ||
              out_res.last != e.last) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_res);
          end
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst_n && (fired || !start)) begin
      fired = 1'b0;
      if (gap > 0) begin
        gap--;
        start  <= 1'b0;
        in_req <= mpsm_in_t'(8'($urandom));
      end else if (pending_reqs.size() > 0) begin
        in_req <= pending_reqs.pop_front();
        start  <= 1'b1;
        if (pending_reqs.size() > QUIET && $urandom_range(0, 7) == 0)
          gap = $urandom_range(1, 18);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= WD_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req      = '0;
    fired       = 1'b0;
    gap         = 0;
    mismatches  = 0;
    idle_cycles = 0;
    for (int i = 0; i < NODES*LETTERS; i++) sh_goto[i] = '0;
    for (int i = 0; i < NODES; i++) begin
      sh_fail[i] = '0; sh_term[i] = '0; sh_cnt[i] = '0; sh_depth[i] = '0; sh_bfs[i] = '0;
    end
    sh_used = 1; sh_ins = 0; sh_scan = 0; sh_pos = '0; sh_built = 1'b0; sh_drop = ST_OK;

    // directed: bad symbols, unused code, scan before build
    add_req(FUNC_INSERT, 27, 1'b1);
    add_req(FUNC_INSERT, 31, 1'b0);
    add_req(FUNC_NONE, 31, 1'b1);
    add_req(FUNC_INSERT, 25, 1'b0);
    add_req(FUNC_INSERT, 24, 1'b1);
    add_req(FUNC_SCAN, 25, 1'b0);
    add_req(FUNC_SCAN, 24, 1'b1);
    add_req(FUNC_SCAN, 30, 1'b0);
    // over-long pattern, letters past the limit keep reporting until its end
    for (int i = 0; i < 35; i++) add_req(FUNC_INSERT, 25, 1'(i == 34));
    // random patterns with noise
    for (int i = 0; i < 150; i++) add_random(FUNC_INSERT);
    add_req(FUNC_INSERT, 1, 1'b1);
    // build with an unfinished pattern pending
    add_req(FUNC_INSERT, 2, 1'b0);
    add_req(FUNC_BUILD, 0, 1'b0);
    add_req(FUNC_INSERT, 3, 1'b1);
    add_req(FUNC_BUILD, 31, 1'b1);
    // random text
    for (int i = 0; i < 260; i++) add_random(FUNC_SCAN);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_reqs.size() == 0 && !start && expected_res.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
